// ----- hw/rtl/dsma_pkg.sv -----
// Shared types, constants and helpers for the dual SMA crossover core.
package dsma_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int WIN_AW     = $clog2(MAX_WINDOW);
    localparam int PER_W      = 7;
    localparam int PRICE_W    = 32;
    localparam int BAL_W      = 48;
    localparam int SUM_W      = PRICE_W + WIN_AW;
    localparam int CNT_W      = 7;
    localparam int DIV_W      = BAL_W + PRICE_W;
    localparam int MUL_W      = DIV_W + 1;
    localparam int STEP_W     = 7;
    localparam int PROD_W     = SUM_W + PER_W;

    localparam logic [PER_W-1:0] SHORT_RST = PER_W'(5);
    localparam logic [PER_W-1:0] LONG_RST  = PER_W'(20);
    localparam logic [BAL_W-1:0] BAL_RST   = BAL_W'(655360000);
    localparam logic [BAL_W-1:0] BAL_MAX   = {BAL_W{1'b1}};

    typedef enum logic [1:0] {
        REG_SHORT = 2'd0,
        REG_LONG  = 2'd1,
        REG_BAL   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } sig_code_t;

    typedef struct packed {
        logic               cmd;
        logic [PRICE_W-1:0] price;
    } req_t;

    typedef struct packed {
        logic [PRICE_W-1:0] short_avg;
        logic [PRICE_W-1:0] long_avg;
        logic               trading_active;
        logic               in_position;
        logic [1:0]         signal;
        logic [BAL_W-1:0]   balance;
    } rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [PRICE_W-1:0] divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic              clear;
        logic              wr;
        logic [PRICE_W-1:0] wdata;
        logic              rd;
        logic [WIN_AW-1:0] rd_off;
    } win_ctl_t;

    // Period 0 acts as 1, anything above the window depth as the depth.
    function automatic logic [PER_W-1:0] clamp_period(input logic [PER_W-1:0] p);
        logic [PER_W-1:0] r;
        r = p;
        if (p == '0)
            r = PER_W'(1);
        else if (p > PER_W'(MAX_WINDOW))
            r = PER_W'(MAX_WINDOW);
        return r;
    endfunction

endpackage

// ----- hw/rtl/dsma_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module dsma_div (
    input  logic                clk,
    input  logic                rst_n,
    input  dsma_pkg::div_req_t  req,
    output dsma_pkg::div_rsp_t  rsp
);

    logic [dsma_pkg::DIV_W-1:0]   num_reg, num_next;
    logic [dsma_pkg::DIV_W-1:0]   quot_reg, quot_next;
    logic [dsma_pkg::PRICE_W-1:0] rem_reg, rem_next;
    logic [dsma_pkg::PRICE_W-1:0] dvs_reg, dvs_next;
    logic [dsma_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [dsma_pkg::PRICE_W:0]   trial;
    logic                         fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[dsma_pkg::DIV_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.dividend;
            quot_next = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = req.steps;
        end
        else if (cnt_reg != '0)
        begin
            num_next  = {num_reg[dsma_pkg::DIV_W-2:0], 1'b0};
            quot_next = {quot_reg[dsma_pkg::DIV_W-2:0], fits};
            rem_next  = fits ? dsma_pkg::PRICE_W'(trial - {1'b0, dvs_reg})
                             : trial[dsma_pkg::PRICE_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == dsma_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ----- hw/rtl/dsma_window.sv -----
// Price window memory with per-entry valid bits and write pointer.
module dsma_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsma_pkg::win_ctl_t            ctl,
    output logic [dsma_pkg::PRICE_W-1:0]  rd_data
);

    logic [dsma_pkg::PRICE_W-1:0]    mem [dsma_pkg::MAX_WINDOW];
    logic [dsma_pkg::MAX_WINDOW-1:0] valid_reg, valid_next;
    logic [dsma_pkg::WIN_AW-1:0]     wp_reg, wp_next;
    logic [dsma_pkg::WIN_AW-1:0]     rd_addr;
    logic [dsma_pkg::PRICE_W-1:0]    rdat_reg;
    logic                            rval_reg;

    // Newest sample sits one behind the write pointer.
    assign rd_addr = wp_reg - ctl.rd_off - 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        wp_next    = wp_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
            wp_next    = '0;
        end
        else if (ctl.wr)
        begin
            valid_next[wp_reg] = 1'b1;
            wp_next            = wp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wp_reg    <= '0;
            rval_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            wp_reg    <= wp_next;
            if (ctl.rd)
                rval_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr && !ctl.clear)
            mem[wp_reg] <= ctl.wdata;
        if (ctl.rd)
            rdat_reg <= mem[rd_addr];
    end

    assign rd_data = rval_reg ? rdat_reg : '0;

endmodule

// ----- hw/rtl/dual_sma_crossover_signal_core.sv -----
// Dual SMA crossover core: window sums, serial divider, crossover and balance.
// Each request writes the window, reads max(short,long) window words, then runs two
//   average divides; compounding adds a 32-step shift-add multiply, then an 80-step divide.
// A new request is taken only once the block is back in idle, after its result is registered;
//   both 38-step average divides share the one serial divider; output stalls hold it in done.
// Reset: rst_n async low; periods 5/20, balance 10000.0, window and series cleared.
module dual_sma_crossover_signal_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  dsma_pkg::req_t        req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output dsma_pkg::rsp_t        rsp,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [dsma_pkg::BAL_W-1:0] cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_WRITE = 11'b00000000010,
        ST_SUM   = 11'b00000000100,
        ST_DIVS  = 11'b00000001000,
        ST_DIVL  = 11'b00000010000,
        ST_PROD  = 11'b00000100000,
        ST_CMP   = 11'b00001000000,
        ST_MUL   = 11'b00010000000,
        ST_DIVB  = 11'b00100000000,
        ST_DONE  = 11'b01000000000,
        ST_SPARE = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [dsma_pkg::PER_W-1:0] sp_cfg_reg, lp_cfg_reg;
    logic [dsma_pkg::BAL_W-1:0] ibal_reg;

    // series state
    logic [dsma_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         hold_reg, hold_next;
    logic [dsma_pkg::PRICE_W-1:0] prev_reg, prev_next;
    logic [dsma_pkg::BAL_W-1:0]   bal_reg, bal_next;

    // per-request working registers
    logic [dsma_pkg::PRICE_W-1:0] price_reg, price_next;
    logic [dsma_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [dsma_pkg::SUM_W-1:0]   ssum_reg, ssum_next, lsum_reg, lsum_next;
    logic [dsma_pkg::CNT_W-1:0]   i_reg, i_next, rdi_reg, rdi_next;
    logic                         rdp_reg, rdp_next;
    logic [dsma_pkg::PRICE_W-1:0] savg_reg, savg_next, lavg_reg, lavg_next;
    logic [dsma_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [1:0]                   sig_reg, sig_next;
    logic [dsma_pkg::MUL_W-1:0]   mul_reg, mul_next;
    logic [5:0]                   mcnt_reg, mcnt_next;

    logic                         ov_reg, ov_next;
    dsma_pkg::rsp_t               out_reg, out_next;

    logic [dsma_pkg::PER_W-1:0]   sp, lp, nmax;
    logic [dsma_pkg::SUM_W-1:0]   s_cmp, l_cmp;
    logic [dsma_pkg::PROD_W-1:0]  prod_l;
    logic                         active;
    logic                         accept;
    logic [dsma_pkg::PRICE_W-1:0] win_data;
    logic [dsma_pkg::BAL_W:0]     mul_add;
    logic [dsma_pkg::MUL_W-1:0]   mul_sum;
    dsma_pkg::win_ctl_t           win_ctl;
    dsma_pkg::div_req_t           dv_req;
    dsma_pkg::div_rsp_t           dv_rsp;

    dsma_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win_ctl),
        .rd_data (win_data)
    );

    dsma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req),
        .rsp   (dv_rsp)
    );

    assign sp     = dsma_pkg::clamp_period(sp_cfg_reg);
    assign lp     = dsma_pkg::clamp_period(lp_cfg_reg);
    assign nmax   = (sp > lp) ? sp : lp;
    // an average joins the compare only once its window has filled
    assign s_cmp  = ({1'b0, idx_reg} + 1'b1 >= {1'b0, sp}) ? ssum_reg : '0;
    assign l_cmp  = ({1'b0, idx_reg} + 1'b1 >= {1'b0, lp}) ? lsum_reg : '0;
    assign active = idx_reg >= lp;
    assign prod_l = l_cmp * sp;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);

    // shift-add multiply: balance * price, one multiplier bit a cycle
    assign mul_add = mul_reg[dsma_pkg::MUL_W-1:dsma_pkg::PRICE_W]
                   + (mul_reg[0] ? {1'b0, bal_reg} : '0);
    assign mul_sum = {1'b0, mul_add, mul_reg[dsma_pkg::PRICE_W-1:1]};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        prev_next  = prev_reg;
        bal_next   = bal_reg;
        price_next = price_reg;
        idx_next   = idx_reg;
        ssum_next  = ssum_reg;
        lsum_next  = lsum_reg;
        i_next     = i_reg;
        rdi_next   = rdi_reg;
        rdp_next   = 1'b0;
        savg_next  = savg_reg;
        lavg_next  = lavg_reg;
        prod_next  = prod_reg;
        sig_next   = sig_reg;
        mul_next   = mul_reg;
        mcnt_next  = mcnt_reg;
        out_next   = out_reg;
        ov_next    = ov_reg && rsp_stall;

        win_ctl        = '0;
        win_ctl.wdata  = price_reg;
        dv_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    price_next = req.price;
                    if (req.cmd)
                    begin
                        // new series: wipe window and reload the balance
                        win_ctl.clear = 1'b1;
                        count_next    = '0;
                        hold_next     = 1'b0;
                        prev_next     = '0;
                        bal_next      = ibal_reg;
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                win_ctl.wr = 1'b1;
                idx_next   = count_reg;
                if (count_reg < dsma_pkg::CNT_W'(dsma_pkg::MAX_WINDOW + 1))
                    count_next = count_reg + 1'b1;
                ssum_next  = '0;
                lsum_next  = '0;
                i_next     = '0;
                sig_next   = dsma_pkg::SIG_NONE;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // one window word per cycle, read data lands in the cycle after the read
                if (i_reg < nmax)
                begin
                    win_ctl.rd     = 1'b1;
                    win_ctl.rd_off = i_reg[dsma_pkg::WIN_AW-1:0];
                    i_next         = i_reg + 1'b1;
                    rdp_next       = 1'b1;
                    rdi_next       = i_reg;
                end
                if (rdp_reg)
                begin
                    if (rdi_reg < sp)
                        ssum_next = ssum_reg + dsma_pkg::SUM_W'(win_data);
                    if (rdi_reg < lp)
                        lsum_next = lsum_reg + dsma_pkg::SUM_W'(win_data);
                end
                if (i_reg == nmax && !rdp_reg)
                begin
                    dv_req.start    = 1'b1;
                    dv_req.dividend = {s_cmp, (dsma_pkg::DIV_W - dsma_pkg::SUM_W)'(0)};
                    dv_req.divisor  = dsma_pkg::PRICE_W'(sp);
                    dv_req.steps    = dsma_pkg::STEP_W'(dsma_pkg::SUM_W);
                    state_next      = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                if (dv_rsp.done)
                begin
                    savg_next       = dv_rsp.quot[dsma_pkg::PRICE_W-1:0];
                    dv_req.start    = 1'b1;
                    dv_req.dividend = {l_cmp, (dsma_pkg::DIV_W - dsma_pkg::SUM_W)'(0)};
                    dv_req.divisor  = dsma_pkg::PRICE_W'(lp);
                    dv_req.steps    = dsma_pkg::STEP_W'(dsma_pkg::SUM_W);
                    state_next      = ST_DIVL;
                end
            end
            ST_DIVL:
            begin
                if (dv_rsp.done)
                begin
                    lavg_next  = dv_rsp.quot[dsma_pkg::PRICE_W-1:0];
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                prod_next  = s_cmp * lp;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // exact crossover: s/sp vs l/lp as s*lp vs l*sp
                state_next = ST_DONE;
                if (active)
                begin
                    if (prod_reg > prod_l && !hold_reg)
                    begin
                        hold_next = 1'b1;
                        sig_next  = dsma_pkg::SIG_BUY;
                    end
                    else if (prod_reg < prod_l && hold_reg)
                    begin
                        hold_next = 1'b0;
                        sig_next  = dsma_pkg::SIG_SELL;
                    end
                    if ((hold_next) && prev_reg != '0)
                    begin
                        mul_next   = {(dsma_pkg::MUL_W - dsma_pkg::PRICE_W)'(0), price_reg};
                        mcnt_next  = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                mul_next  = mul_sum;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 6'(dsma_pkg::PRICE_W - 1))
                begin
                    dv_req.start    = 1'b1;
                    dv_req.dividend = mul_sum[dsma_pkg::DIV_W-1:0];
                    dv_req.divisor  = prev_reg;
                    dv_req.steps    = dsma_pkg::STEP_W'(dsma_pkg::DIV_W);
                    state_next      = ST_DIVB;
                end
            end
            ST_DIVB:
            begin
                if (dv_rsp.done)
                begin
                    bal_next = (dv_rsp.quot[dsma_pkg::DIV_W-1:dsma_pkg::BAL_W] != '0)
                             ? dsma_pkg::BAL_MAX
                             : dv_rsp.quot[dsma_pkg::BAL_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                prev_next = price_reg;
                if (!ov_reg || !rsp_stall)
                begin
                    out_next.short_avg      = savg_reg;
                    out_next.long_avg       = lavg_reg;
                    out_next.trading_active = active;
                    out_next.in_position    = hold_reg;
                    out_next.signal         = sig_reg;
                    out_next.balance        = bal_reg;
                    ov_next                 = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sp_cfg_reg <= dsma_pkg::SHORT_RST;
            lp_cfg_reg <= dsma_pkg::LONG_RST;
            ibal_reg   <= dsma_pkg::BAL_RST;
            count_reg  <= '0;
            hold_reg   <= 1'b0;
            prev_reg   <= '0;
            bal_reg    <= dsma_pkg::BAL_RST;
            rdp_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
            prev_reg  <= prev_next;
            bal_reg   <= bal_next;
            rdp_reg   <= rdp_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dsma_pkg::REG_SHORT: sp_cfg_reg <= cfg_data[dsma_pkg::PER_W-1:0];
                    dsma_pkg::REG_LONG:  lp_cfg_reg <= cfg_data[dsma_pkg::PER_W-1:0];
                    dsma_pkg::REG_BAL:   ibal_reg   <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        idx_reg   <= idx_next;
        ssum_reg  <= ssum_next;
        lsum_reg  <= lsum_next;
        i_reg     <= i_next;
        rdi_reg   <= rdi_next;
        savg_reg  <= savg_next;
        lavg_reg  <= lavg_next;
        prod_reg  <= prod_next;
        sig_reg   <= sig_next;
        mul_reg   <= mul_next;
        mcnt_reg  <= mcnt_next;
        out_reg   <= out_next;
    end

    assign rsp_valid = ov_reg;
    assign rsp       = out_reg;

    // a buy always leaves the block holding and trading
    a_buy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.signal == dsma_pkg::SIG_BUY |-> rsp.in_position && rsp.trading_active)
        else $error("buy without position");

    // a sell always leaves the block flat
    a_sell_flat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.signal == dsma_pkg::SIG_SELL |-> !rsp.in_position)
        else $error("sell while holding");

    // no signal before trading starts
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.trading_active |-> rsp.signal == dsma_pkg::SIG_NONE)
        else $error("signal while inactive");

    // compounding never divides by a zero previous price
    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVB |-> prev_reg != '0)
        else $error("zero divisor");

endmodule

// ----- tb/tb_dual_sma_crossover_signal_core.sv -----
// Testbench for the dual SMA crossover core: scoreboard prediction and random traffic.
module tb_dual_sma_crossover_signal_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts each result of the crossover core and checks the block's output.
    class crossover_scoreboard;
        logic [dsma_pkg::PER_W-1:0]   short_len;
        logic [dsma_pkg::PER_W-1:0]   long_len;
        logic [dsma_pkg::BAL_W-1:0]   start_balance;
        logic [dsma_pkg::PRICE_W-1:0] prices [dsma_pkg::MAX_WINDOW];
        int                           wr_pos;
        int                           seen;
        bit                           long_held;
        logic [dsma_pkg::PRICE_W-1:0] last_price;
        logic [dsma_pkg::BAL_W-1:0]   cash;
        dsma_pkg::rsp_t               pending [$];
        int                           errors;
        int                           matched;
        int                           buys;
        int                           sells;

        function void restart_series();
            foreach (prices[i]) prices[i] = '0;
            wr_pos = 0;
            seen = 0;
            long_held = 0;
            last_price = '0;
            cash = start_balance;
        endfunction

        function void power_up();
            short_len = dsma_pkg::SHORT_RST;
            long_len = dsma_pkg::LONG_RST;
            start_balance = dsma_pkg::BAL_RST;
            errors = 0;
            matched = 0;
            buys = 0;
            sells = 0;
            restart_series();
        endfunction

        function void write_reg(dsma_pkg::cfg_index_t idx,
                                logic [dsma_pkg::BAL_W-1:0] value);
            case (idx)
                dsma_pkg::REG_SHORT: short_len = value[dsma_pkg::PER_W-1:0];
                dsma_pkg::REG_LONG:  long_len = value[dsma_pkg::PER_W-1:0];
                dsma_pkg::REG_BAL:   start_balance = value;
                default:             ;
            endcase
        endfunction

        function logic [dsma_pkg::SUM_W-1:0] recent_sum(int n);
            logic [dsma_pkg::SUM_W-1:0] s;
            s = '0;
            for (int i = 0; i < n; i++)
                s += prices[(wr_pos + 2 * dsma_pkg::MAX_WINDOW - 1 - i) % dsma_pkg::MAX_WINDOW];
            return s;
        endfunction

        function void note_request(dsma_pkg::req_t r);
            int                         sp, lp, idx;
            logic [dsma_pkg::SUM_W-1:0] s_cmp, l_cmp;
            logic [127:0]               lhs, rhs, scaled;
            dsma_pkg::sig_code_t        sig;
            dsma_pkg::rsp_t             e;
            sp = int'(dsma_pkg::clamp_period(short_len));
            lp = int'(dsma_pkg::clamp_period(long_len));
            sig = dsma_pkg::SIG_NONE;
            if (r.cmd) restart_series();
            idx = seen;
            prices[wr_pos] = r.price;
            wr_pos = (wr_pos + 1) % dsma_pkg::MAX_WINDOW;
            if (seen < dsma_pkg::MAX_WINDOW + 1) seen++;
            s_cmp = (idx + 1 >= sp) ? recent_sum(sp) : '0;
            l_cmp = (idx + 1 >= lp) ? recent_sum(lp) : '0;
            e.trading_active = idx >= lp;
            if (e.trading_active)
            begin
                // exact comparison of s/sp against l/lp by cross-multiplying
                lhs = 128'(s_cmp) * 128'(lp);
                rhs = 128'(l_cmp) * 128'(sp);
                if (lhs > rhs && !long_held)
                begin
                    long_held = 1;
                    sig = dsma_pkg::SIG_BUY;
                    buys++;
                end
                else if (lhs < rhs && long_held)
                begin
                    long_held = 0;
                    sig = dsma_pkg::SIG_SELL;
                    sells++;
                end
                if (long_held && last_price != 0)
                begin
                    scaled = (128'(cash) * 128'(r.price)) / 128'(last_price);
                    cash = (scaled > 128'(dsma_pkg::BAL_MAX)) ? dsma_pkg::BAL_MAX
                                                              : scaled[dsma_pkg::BAL_W-1:0];
                end
            end
            last_price = r.price;
            e.short_avg = dsma_pkg::PRICE_W'(s_cmp / dsma_pkg::SUM_W'(sp));
            e.long_avg = dsma_pkg::PRICE_W'(l_cmp / dsma_pkg::SUM_W'(lp));
            e.in_position = long_held;
            e.signal = sig;
            e.balance = cash;
            pending = {pending, e};
        endfunction

        function void check_result(dsma_pkg::rsp_t got);
            dsma_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            matched++;
            if (got.short_avg !== e.short_avg)
            begin
                $error("short_avg expected %h actual %h", e.short_avg, got.short_avg);
                errors++;
            end
            if (got.long_avg !== e.long_avg)
            begin
                $error("long_avg expected %h actual %h", e.long_avg, got.long_avg);
                errors++;
            end
            if (got.trading_active !== e.trading_active)
            begin
                $error("trading_active expected %b actual %b",
                       e.trading_active, got.trading_active);
                errors++;
            end
            if (got.in_position !== e.in_position)
            begin
                $error("in_position expected %b actual %b", e.in_position, got.in_position);
                errors++;
            end
            if (got.signal !== e.signal)
            begin
                $error("signal expected %0d actual %0d", e.signal, got.signal);
                errors++;
            end
            if (got.balance !== e.balance)
            begin
                $error("balance expected %h actual %h", e.balance, got.balance);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 4_000_000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        req_valid = 0;
    logic        req_stall;
    dsma_pkg::req_t req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 0;
    dsma_pkg::rsp_t rsp;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [dsma_pkg::BAL_W-1:0] cfg_data = '0;

    crossover_scoreboard sb;
    int  cycles = 0;
    bit  calm = 0;        // no idling on either side
    bit  hold_off = 0;    // receiver blocked for a long stretch
    int  requests = 0;
    logic [dsma_pkg::PRICE_W-1:0] walk;

    dual_sma_crossover_signal_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Run guard: a hung block must not hang the simulation.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: check accepted results, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
    end

    always @(negedge clk)
    begin
        if (hold_off) rsp_stall <= 1;
        else if (calm) rsp_stall <= 0;
        else rsp_stall <= ($urandom_range(99) < 37);
    end

    // Long receiver hold-off, counted here, so the block backs up into its input.
    task automatic hold_receiver(int n);
        hold_off = 1;
        repeat (n) @(posedge clk);
        hold_off = 0;
    endtask

    // Offer one request; hold it until accepted. Random gaps before it.
    task automatic send_request(logic cmd, logic [dsma_pkg::PRICE_W-1:0] price);
        dsma_pkg::req_t r;
        r.cmd = cmd;
        r.price = price;
        while (!calm && $urandom_range(99) < 37)
        begin
            @(negedge clk);
            req_valid <= 0;
        end
        @(negedge clk);
        req_valid <= 1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(r);
        requests++;
        @(negedge clk);
        req_valid <= 0;
    endtask

    // Let every expected result drain, then pause for the block's latency.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(dsma_pkg::cfg_index_t idx, logic [dsma_pkg::BAL_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, value);
    endtask

    // Random price: mostly a trending random walk, sometimes extremes or noise.
    function automatic logic [dsma_pkg::PRICE_W-1:0] next_price();
        int k;
        k = $urandom_range(99);
        if (k < 4) return '1;
        if (k < 8) return dsma_pkg::PRICE_W'(1);
        if (k < 14) return $urandom() | 1;
        walk = walk + dsma_pkg::PRICE_W'($urandom_range(8192))
                    - dsma_pkg::PRICE_W'(4000 + $urandom_range(300));
        if (walk == 0 || walk[dsma_pkg::PRICE_W-1]) walk = 32'h0064_0000;
        return walk;
    endfunction

    // One series of n prices under the current settings.
    task automatic run_series(int n);
        send_request(1'b1, next_price());
        for (int i = 1; i < n; i++)
            send_request($urandom_range(99) == 0, next_price());
    endtask

    initial
    begin
        sb = new();
        sb.power_up();
        walk = 32'h0064_0000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: periods 2 and 4, extremes of price, then a climb and a fall to force
        // a buy and a sell with compounding; zero previous price can't arise since
        // price is at least 1, but price 1 and all-ones are both covered.
        calm = 1;
        write_reg(dsma_pkg::REG_SHORT, dsma_pkg::BAL_W'(2));
        write_reg(dsma_pkg::REG_LONG, dsma_pkg::BAL_W'(4));
        send_request(1'b1, '1);
        send_request(1'b0, 32'd1);
        send_request(1'b0, '1);
        send_request(1'b0, 32'd1);
        for (int i = 0; i < 6; i++) send_request(1'b0, 32'h0001_0000 << i);
        for (int i = 0; i < 6; i++) send_request(1'b0, 32'h0020_0000 >> i);
        drain();
        // Period 0 acts as 1; period above depth acts as depth; short above long.
        write_reg(dsma_pkg::REG_SHORT, '0);
        write_reg(dsma_pkg::REG_LONG, dsma_pkg::BAL_W'(127));
        write_reg(dsma_pkg::REG_BAL, dsma_pkg::BAL_MAX);
        send_request(1'b1, 32'hAAAA_5555);
        send_request(1'b0, 32'h5555_AAAA);
        drain();
        write_reg(dsma_pkg::REG_SHORT, dsma_pkg::BAL_W'(9));
        write_reg(dsma_pkg::REG_LONG, dsma_pkg::BAL_W'(3));
        write_reg(dsma_pkg::REG_BAL, '0);
        for (int i = 0; i < 6; i++) send_request(i == 0, 32'h0003_0000 + i);
        drain();
        calm = 0;

        // Random settings, one phase each; extremes among them.
        for (int ph = 0; ph < 24; ph++)
        begin
            logic [dsma_pkg::BAL_W-1:0] bal;
            int lp, sp, n;
            case (ph % 4)
                0:
                begin
                    lp = $urandom_range(1, 8);
                    sp = $urandom_range(0, lp);
                end
                1:
                begin
                    lp = $urandom_range(5, 30);
                    sp = $urandom_range(1, lp);
                end
                2:
                begin
                    lp = (ph == 6) ? 64 : $urandom_range(60, 127);
                    sp = $urandom_range(0, 127);
                end
                default:
                begin
                    lp = $urandom_range(0, 127);
                    sp = $urandom_range(0, 127);
                end
            endcase
            bal = (ph % 5 == 0) ? dsma_pkg::BAL_MAX
                                : dsma_pkg::BAL_W'({$urandom(), $urandom()});
            if (ph % 7 == 3) bal = '0;
            write_reg(dsma_pkg::REG_SHORT, dsma_pkg::BAL_W'(sp));
            write_reg(dsma_pkg::REG_LONG, dsma_pkg::BAL_W'(lp));
            write_reg(dsma_pkg::REG_BAL, bal);
            calm = (ph == 10);
            if (ph == 4)
            begin
                fork
                    hold_receiver(3000);
                join_none
            end
            n = (lp > 40) ? 100 : 70;
            repeat (n / 35) run_series(35);
            calm = 0;
            drain();
        end

        drain();
        $display("Sent %0d requests, %0d results checked; %0d buys and %0d sells seen.",
                 requests, sb.matched, sb.buys, sb.sells);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
